>>> src/two_class_buffer_pool_allocator_unit_macros.svh
// assertion macros used by the buffer pool allocator datapath
`ifndef TWO_CLASS_BUFFER_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define TWO_CLASS_BUFFER_POOL_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication on clk, disabled in reset
`define TCBPA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcbpa assertion failed");

// next-cycle implication on clk, disabled in reset
`define TCBPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcbpa assertion failed");

`endif

>>> src/tcbpa_pkg.sv
// types and constants of the two-class buffer pool allocator
`timescale 1ns / 1ps

package tcbpa_pkg;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] CFG_SMALL_BYTES  = 2'd0;
    localparam logic [1:0] CFG_LARGE_BYTES  = 2'd1;
    localparam logic [1:0] CFG_HEADER_BYTES = 2'd2;

    localparam logic [15:0] SMALL_BYTES_RESET  = 16'd2048;
    localparam logic [15:0] LARGE_BYTES_RESET  = 16'd16384;
    localparam logic [11:0] HEADER_BYTES_RESET = 12'd128;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_TOO_LARGE    = 3'd1,
        STAT_EMPTY        = 3'd2,
        STAT_ALREADY_FREE = 3'd3,
        STAT_BAD_ID       = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_size;
        logic [10:0] buffer_id;
    } req_payload_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [10:0] granted_id;
        logic [10:0] small_free_count;
        logic [7:0]  large_free_count;
    } rsp_payload_t;

    typedef struct packed {
        logic accept;
        logic commit;
        logic clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_room;
        logic clear_last;
    } dp_status_t;

endpackage

>>> src/tcbpa_stream_if.sv
// valid/ready stream channel carrying one payload type
`timescale 1ns / 1ps

interface tcbpa_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> src/tcbpa_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module tcbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/tcbpa_ctrl.sv
// controller state machine: clearing pass, accept and commit sequencing
`timescale 1ns / 1ps

module tcbpa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tcbpa_pkg::dp_status_t  stat,
    input  logic                   req_valid,
    output logic                   req_ready,
    output tcbpa_pkg::ctrl_cmd_t   cmd
);

    tcbpa_pkg::state_t state_reg;
    tcbpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcbpa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            tcbpa_pkg::S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = tcbpa_pkg::S_IDLE;
                end
            end
            tcbpa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tcbpa_pkg::S_EXEC;
                end
            end
            tcbpa_pkg::S_EXEC:
            begin
                // wait here only while the output register holds an untaken result
                if (stat.out_room)
                begin
                    cmd.commit = 1'b1;
                    state_next = tcbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tcbpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> src/tcbpa_datapath.sv
// datapath: free stacks, low-water marks, free-flag memory, result register
`timescale 1ns / 1ps
`include "two_class_buffer_pool_allocator_unit_macros.svh"

module tcbpa_datapath #(
    parameter int SMALL_COUNT = 1024,
    parameter int LARGE_COUNT = 128
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  tcbpa_pkg::ctrl_cmd_t    cmd,
    output tcbpa_pkg::dp_status_t   stat,
    input  tcbpa_pkg::req_payload_t req_payload,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_addr,
    input  logic [15:0]             cfg_wdata,
    output logic                    rsp_valid,
    output tcbpa_pkg::rsp_payload_t rsp_payload,
    input  logic                    rsp_ready
);

    localparam int TOTAL = SMALL_COUNT + LARGE_COUNT;
    localparam int SAW   = SMALL_COUNT > 1 ? $clog2(SMALL_COUNT) : 1;
    localparam int LAW   = LARGE_COUNT > 1 ? $clog2(LARGE_COUNT) : 1;
    localparam int SCW   = $clog2(SMALL_COUNT + 1);
    localparam int LCW   = $clog2(LARGE_COUNT + 1);
    localparam int FAW   = $clog2(TOTAL);
    localparam int CMPW  = (FAW >= 11 ? FAW : 11) + 1;

    // configuration
    logic [15:0] small_bytes_reg;
    logic [15:0] large_bytes_reg;
    logic [11:0] header_bytes_reg;

    // pool state
    logic [SCW-1:0] small_cnt_reg, small_cnt_next;
    logic [SCW-1:0] small_lw_reg, small_lw_next;
    logic [LCW-1:0] large_cnt_reg, large_cnt_next;
    logic [LCW-1:0] large_lw_reg, large_lw_next;
    logic [FAW-1:0] clr_addr_reg;

    // captured transaction
    logic                kind_reg;
    tcbpa_pkg::status_t  pre_status_reg, pre_status_next;
    logic                use_large_reg, use_large_next;
    logic [CMPW-1:0]     id_reg;

    // result register
    logic                    rsp_valid_reg;
    tcbpa_pkg::rsp_payload_t rsp_payload_reg, rsp_payload_next;

    logic [16:0]     total_bytes;
    logic            too_large;
    logic            want_large;
    logic [CMPW-1:0] id_ext;
    logic            id_bad;
    logic            id_large;

    logic [SCW-1:0]  small_pop_pos;
    logic [LCW-1:0]  large_pop_pos;
    logic [SAW-1:0]  small_rdata;
    logic [LAW-1:0]  large_rdata;
    logic            flag_rdata;
    logic [SAW-1:0]  small_pop_val;
    logic [LAW-1:0]  large_pop_val;
    logic [CMPW-1:0] gid;
    logic [CMPW-1:0] large_idx;

    logic            is_alloc;
    logic            pre_ok;
    logic            alloc_ok;
    logic            free_ok;
    tcbpa_pkg::status_t final_status;

    logic            small_we;
    logic            large_we;
    logic            flag_we;
    logic [FAW-1:0]  flag_waddr;
    logic            flag_wdata;

    // request classification at accept
    always_comb
    begin
        total_bytes = 17'(req_payload.request_size) + 17'(header_bytes_reg);
        too_large   = total_bytes > 17'(large_bytes_reg);
        want_large  = total_bytes > 17'(small_bytes_reg);
        id_ext      = CMPW'(req_payload.buffer_id);
        id_bad      = id_ext >= CMPW'(TOTAL);
        id_large    = id_ext >= CMPW'(SMALL_COUNT);

        if (req_payload.kind == tcbpa_pkg::KIND_ALLOC)
        begin
            use_large_next = want_large;
            if (too_large)
            begin
                pre_status_next = tcbpa_pkg::STAT_TOO_LARGE;
            end
            else if (want_large && large_cnt_reg == '0)
            begin
                pre_status_next = tcbpa_pkg::STAT_EMPTY;
            end
            else if (!want_large && small_cnt_reg == '0)
            begin
                pre_status_next = tcbpa_pkg::STAT_EMPTY;
            end
            else
            begin
                pre_status_next = tcbpa_pkg::STAT_OK;
            end
        end
        else
        begin
            use_large_next  = id_large;
            pre_status_next = id_bad ? tcbpa_pkg::STAT_BAD_ID : tcbpa_pkg::STAT_OK;
        end
    end

    assign small_pop_pos = small_cnt_reg - SCW'(1);
    assign large_pop_pos = large_cnt_reg - LCW'(1);

    // stack slots below the low-water mark were never written and stand for their own index
    assign small_pop_val = (small_pop_pos < small_lw_reg) ? small_pop_pos[SAW-1:0] : small_rdata;
    assign large_pop_val = (large_pop_pos < large_lw_reg) ? large_pop_pos[LAW-1:0] : large_rdata;

    assign gid = use_large_reg ? (CMPW'(SMALL_COUNT) + CMPW'(large_pop_val))
                               : CMPW'(small_pop_val);
    assign large_idx = id_reg - CMPW'(SMALL_COUNT);

    assign is_alloc = (kind_reg == tcbpa_pkg::KIND_ALLOC);
    assign pre_ok   = (pre_status_reg == tcbpa_pkg::STAT_OK);
    assign alloc_ok = is_alloc && pre_ok;
    assign free_ok  = !is_alloc && pre_ok && !flag_rdata;

    assign final_status = (!is_alloc && pre_ok && flag_rdata) ? tcbpa_pkg::STAT_ALREADY_FREE
                                                              : pre_status_reg;

    assign small_we = cmd.commit && free_ok && !use_large_reg
                      && (small_cnt_reg < SCW'(SMALL_COUNT));
    assign large_we = cmd.commit && free_ok && use_large_reg
                      && (large_cnt_reg < LCW'(LARGE_COUNT));

    always_comb
    begin
        small_cnt_next = small_cnt_reg;
        small_lw_next  = small_lw_reg;
        large_cnt_next = large_cnt_reg;
        large_lw_next  = large_lw_reg;
        if (cmd.commit && alloc_ok)
        begin
            if (use_large_reg)
            begin
                large_cnt_next = large_pop_pos;
                if (large_pop_pos < large_lw_reg)
                begin
                    large_lw_next = large_pop_pos;
                end
            end
            else
            begin
                small_cnt_next = small_pop_pos;
                if (small_pop_pos < small_lw_reg)
                begin
                    small_lw_next = small_pop_pos;
                end
            end
        end
        if (small_we)
        begin
            small_cnt_next = small_cnt_reg + SCW'(1);
        end
        if (large_we)
        begin
            large_cnt_next = large_cnt_reg + LCW'(1);
        end
    end

    always_comb
    begin
        if (cmd.clear)
        begin
            flag_we    = 1'b1;
            flag_waddr = clr_addr_reg;
            flag_wdata = 1'b1;
        end
        else
        begin
            flag_we    = cmd.commit && (alloc_ok || free_ok);
            flag_waddr = alloc_ok ? gid[FAW-1:0] : id_reg[FAW-1:0];
            flag_wdata = !alloc_ok;
        end
    end

    always_comb
    begin
        rsp_payload_next.status           = final_status;
        rsp_payload_next.granted_id       = alloc_ok ? gid[10:0] : 11'd0;
        rsp_payload_next.small_free_count = 11'(small_cnt_next);
        rsp_payload_next.large_free_count = 8'(large_cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_bytes_reg  <= tcbpa_pkg::SMALL_BYTES_RESET;
            large_bytes_reg  <= tcbpa_pkg::LARGE_BYTES_RESET;
            header_bytes_reg <= tcbpa_pkg::HEADER_BYTES_RESET;
            small_cnt_reg    <= SCW'(SMALL_COUNT);
            small_lw_reg     <= SCW'(SMALL_COUNT);
            large_cnt_reg    <= LCW'(LARGE_COUNT);
            large_lw_reg     <= LCW'(LARGE_COUNT);
            clr_addr_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    tcbpa_pkg::CFG_SMALL_BYTES:  small_bytes_reg  <= cfg_wdata;
                    tcbpa_pkg::CFG_LARGE_BYTES:  large_bytes_reg  <= cfg_wdata;
                    tcbpa_pkg::CFG_HEADER_BYTES: header_bytes_reg <= cfg_wdata[11:0];
                    default:                     ;
                endcase
            end
            small_cnt_reg <= small_cnt_next;
            small_lw_reg  <= small_lw_next;
            large_cnt_reg <= large_cnt_next;
            large_lw_reg  <= large_lw_next;
            if (cmd.clear)
            begin
                clr_addr_reg <= clr_addr_reg + FAW'(1);
            end
            if (cmd.commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg       <= req_payload.kind;
            pre_status_reg <= pre_status_next;
            use_large_reg  <= use_large_next;
            id_reg         <= id_ext;
        end
        if (cmd.commit)
        begin
            rsp_payload_reg <= rsp_payload_next;
        end
    end

    tcbpa_ram #(.WIDTH(SAW), .DEPTH(SMALL_COUNT)) u_small_stack (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_cnt_reg[SAW-1:0]),
        .wdata (id_reg[SAW-1:0]),
        .re    (cmd.accept),
        .raddr (small_pop_pos[SAW-1:0]),
        .rdata (small_rdata)
    );

    tcbpa_ram #(.WIDTH(LAW), .DEPTH(LARGE_COUNT)) u_large_stack (
        .clk   (clk),
        .we    (large_we),
        .waddr (large_cnt_reg[LAW-1:0]),
        .wdata (large_idx[LAW-1:0]),
        .re    (cmd.accept),
        .raddr (large_pop_pos[LAW-1:0]),
        .rdata (large_rdata)
    );

    tcbpa_ram #(.WIDTH(1), .DEPTH(TOTAL)) u_free_flags (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (cmd.accept),
        .raddr (id_ext[FAW-1:0]),
        .rdata (flag_rdata)
    );

    assign stat.out_room   = !rsp_valid_reg || rsp_ready;
    assign stat.clear_last = (clr_addr_reg == FAW'(TOTAL - 1));

    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_payload_reg;

    `TCBPA_ASSERT_IMPL(a_small_lw_below_cnt, 1'b1, small_lw_reg <= small_cnt_reg)
    `TCBPA_ASSERT_IMPL(a_large_lw_below_cnt, 1'b1, large_lw_reg <= large_cnt_reg)
    `TCBPA_ASSERT_IMPL(a_commit_has_room, cmd.commit, !rsp_valid_reg || rsp_ready)
    `TCBPA_ASSERT_NEXT(a_failed_keeps_counts, cmd.commit && !pre_ok,
        $stable(small_cnt_reg) && $stable(large_cnt_reg))
    `TCBPA_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid_reg)

endmodule

>>> src/two_class_buffer_pool_allocator_unit.sv
// top level of the two-class buffer pool allocator
// result: registered on commit, after the stack/flag read that the accept starts
// requests: a new one is taken only after the previous commit, since the stack ram read is registered and
//   its address comes from the free count that the previous transaction updates
// reset: after rst_n rises a clearing pass over all SMALL_COUNT + LARGE_COUNT free flags sets
//   each of them; no request is taken meanwhile, config writes are
`timescale 1ns / 1ps

module two_class_buffer_pool_allocator_unit #(
    parameter int SMALL_COUNT = 1024,
    parameter int LARGE_COUNT = 128
) (
    input  logic                  clk,
    input  logic                  rst_n,
    tcbpa_stream_if.sink          req,
    tcbpa_stream_if.source        rsp,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata
);

    tcbpa_pkg::ctrl_cmd_t    cmd;
    tcbpa_pkg::dp_status_t   stat;
    tcbpa_pkg::req_payload_t req_payload;
    tcbpa_pkg::rsp_payload_t rsp_payload;
    logic                    rsp_valid;
    logic                    req_ready;

    assign req_payload = req.payload;
    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_payload;

    tcbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .stat      (stat),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .cmd       (cmd)
    );

    tcbpa_datapath #(
        .SMALL_COUNT (SMALL_COUNT),
        .LARGE_COUNT (LARGE_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .req_payload (req_payload),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .rsp_valid   (rsp_valid),
        .rsp_payload (rsp_payload),
        .rsp_ready   (rsp.ready)
    );

endmodule

>>> tb/sv/tb.sv
// self-checking testbench for the two-class buffer pool allocator
`timescale 1ns / 1ps

module tb;

    localparam int SMALL_N = 1024;
    localparam int LARGE_N = 128;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        tcbpa_pkg::req_payload_t item;
        bit                      has_exp;
        tcbpa_pkg::rsp_payload_t due;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    tcbpa_stream_if #(.payload_t(tcbpa_pkg::req_payload_t)) req_if ();
    tcbpa_stream_if #(.payload_t(tcbpa_pkg::rsp_payload_t)) rsp_if ();

    two_class_buffer_pool_allocator_unit #(
        .SMALL_COUNT(SMALL_N),
        .LARGE_COUNT(LARGE_N)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic [9:0]  small_stack [SMALL_N];
    logic [6:0]  large_stack [LARGE_N];
    logic [10:0] small_free;
    logic [7:0]  large_free;
    bit          free_flag [SMALL_N + LARGE_N];
    logic [15:0] small_bytes_cfg;
    logic [15:0] large_bytes_cfg;
    logic [11:0] header_bytes_cfg;

    tcbpa_pkg::rsp_payload_t pool_results_due [$];
    logic [10:0]             held_ids [$];
    plan_row_t               directed_rows [$];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    int                      idle_odds = 0;

    task automatic report_mismatch(input string field, input int got_v, input int exp_v);
        $display("mismatch on %s: got %0d, expected %0d", field, got_v, exp_v);
        mismatch_count++;
    endtask

    task automatic pool_reset();
        for (int i = 0; i < SMALL_N; i++)
            small_stack[i] = 10'(i);
        for (int i = 0; i < LARGE_N; i++)
            large_stack[i] = 7'(i);
        for (int i = 0; i < SMALL_N + LARGE_N; i++)
            free_flag[i] = 1'b1;
        small_free = 11'(SMALL_N);
        large_free = 8'(LARGE_N);
        small_bytes_cfg = tcbpa_pkg::SMALL_BYTES_RESET;
        large_bytes_cfg = tcbpa_pkg::LARGE_BYTES_RESET;
        header_bytes_cfg = tcbpa_pkg::HEADER_BYTES_RESET;
    endtask

    function automatic tcbpa_pkg::rsp_payload_t pool_step(input tcbpa_pkg::req_payload_t r);
        tcbpa_pkg::rsp_payload_t o;
        logic [16:0]  total;
        logic [10:0]  gid;
        o = '0;
        if (r.kind == tcbpa_pkg::KIND_ALLOC)
        begin
            total = {1'b0, r.request_size} + {5'b0, header_bytes_cfg};
            if (total > {1'b0, large_bytes_cfg})
                o.status = tcbpa_pkg::STAT_TOO_LARGE;
            else if (total > {1'b0, small_bytes_cfg})
            begin
                // no fallback: the large class alone serves this size
                if (large_free == 0)
                    o.status = tcbpa_pkg::STAT_EMPTY;
                else
                begin
                    large_free = large_free - 1'b1;
                    gid = 11'(SMALL_N) + {4'b0, large_stack[large_free]};
                    free_flag[gid] = 1'b0;
                    o.status = tcbpa_pkg::STAT_OK;
                    o.granted_id = gid;
                end
            end
            else if (small_free == 0)
                o.status = tcbpa_pkg::STAT_EMPTY;
            else
            begin
                small_free = small_free - 1'b1;
                gid = {1'b0, small_stack[small_free]};
                free_flag[gid] = 1'b0;
                o.status = tcbpa_pkg::STAT_OK;
                o.granted_id = gid;
            end
        end
        else if (r.buffer_id >= SMALL_N + LARGE_N)
            o.status = tcbpa_pkg::STAT_BAD_ID;
        else if (free_flag[r.buffer_id])
            o.status = tcbpa_pkg::STAT_ALREADY_FREE;
        else
        begin
            if (r.buffer_id < SMALL_N)
            begin
                if (small_free < SMALL_N)
                begin
                    small_stack[small_free] = r.buffer_id[9:0];
                    small_free = small_free + 1'b1;
                end
            end
            else if (large_free < LARGE_N)
            begin
                large_stack[large_free] = r.buffer_id[6:0];
                large_free = large_free + 1'b1;
            end
            free_flag[r.buffer_id] = 1'b1;
            o.status = tcbpa_pkg::STAT_OK;
        end
        o.small_free_count = small_free;
        o.large_free_count = large_free;
        return o;
    endfunction

    function automatic void plan(input logic kind, input int size, input int id, input bit has,
                                 input tcbpa_pkg::status_t st, input int gid, input int sc,
                                 input int lc);
        plan_row_t row;
        row.item.kind = kind;
        row.item.request_size = 16'(size);
        row.item.buffer_id = 11'(id);
        row.has_exp = has;
        row.due.status = st;
        row.due.granted_id = 11'(gid);
        row.due.small_free_count = 11'(sc);
        row.due.large_free_count = 8'(lc);
        directed_rows.push_back(row);
    endfunction

    function automatic tcbpa_pkg::req_payload_t make_alloc(input bit small_only);
        tcbpa_pkg::req_payload_t r;
        int t_small;
        int t_large;
        int sz;
        t_small = int'(small_bytes_cfg) - int'(header_bytes_cfg);
        t_large = int'(large_bytes_cfg) - int'(header_bytes_cfg);
        if (small_only)
            sz = $urandom_range(0, t_small > 0 ? t_small : 0);
        else
        begin
            case ($urandom_range(0, 7))
                0: sz = $urandom_range(0, t_small > 0 ? t_small : 0);
                1: sz = t_small - 1 + int'($urandom_range(0, 2));
                2: sz = t_large - 1 + int'($urandom_range(0, 2));
                3: sz = $urandom_range(t_small > 0 ? t_small : 0, t_large > 0 ? t_large : 0);
                4: sz = 65535;
                5: sz = 0;
                default: sz = $urandom_range(0, 65535);
            endcase
        end
        if (sz < 0)
            sz = 0;
        if (sz > 65535)
            sz = 65535;
        r.kind = tcbpa_pkg::KIND_ALLOC;
        r.request_size = 16'(sz);
        r.buffer_id = 11'($urandom_range(0, 2047));
        return r;
    endfunction

    function automatic tcbpa_pkg::req_payload_t make_free();
        tcbpa_pkg::req_payload_t r;
        int pick;
        r.kind = tcbpa_pkg::KIND_FREE;
        r.request_size = 16'($urandom_range(0, 65535));
        pick = $urandom_range(1, 10);
        if (pick <= 8 && held_ids.size() != 0)
            r.buffer_id = held_ids[$urandom_range(0, held_ids.size() - 1)];
        else if (pick == 9)
            r.buffer_id = 11'($urandom_range(SMALL_N + LARGE_N, 2047));
        else
            r.buffer_id = 11'($urandom_range(0, SMALL_N + LARGE_N - 1));
        return r;
    endfunction

    task automatic push_request(input tcbpa_pkg::req_payload_t item, input bit has_exp,
                                input tcbpa_pkg::rsp_payload_t typed);
        tcbpa_pkg::rsp_payload_t pred;
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pred = pool_step(item);
        if (pred.status == tcbpa_pkg::STAT_OK && item.kind == tcbpa_pkg::KIND_ALLOC)
            held_ids.push_back(pred.granted_id);
        else if (pred.status == tcbpa_pkg::STAT_OK)
        begin
            for (int k = 0; k < held_ids.size(); k++)
            begin
                if (held_ids[k] == item.buffer_id)
                begin
                    held_ids.delete(k);
                    break;
                end
            end
        end
        pool_results_due.push_back(has_exp ? typed : pred);
    endtask

    task automatic run_mix(input int count, input int alloc_pct, input bit small_only);
        tcbpa_pkg::req_payload_t r;
        for (int i = 0; i < count; i++)
        begin
            if (held_ids.size() == 0 || $urandom_range(1, 100) <= alloc_pct)
                r = make_alloc(small_only);
            else
                r = make_free();
            push_request(r, 1'b0, '0);
        end
    endtask

    // block idle: nothing in flight, plus the pipeline latency
    task automatic drain_and_wait();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pool_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_sizes(input logic [15:0] sb, input logic [15:0] lb, input logic [11:0] hb);
        cfg_we <= 1'b1;
        cfg_addr <= tcbpa_pkg::CFG_SMALL_BYTES;
        cfg_wdata <= sb;
        small_bytes_cfg = sb;
        @(posedge clk);
        cfg_addr <= tcbpa_pkg::CFG_LARGE_BYTES;
        cfg_wdata <= lb;
        large_bytes_cfg = lb;
        @(posedge clk);
        // upper bits beyond the header width are junk the block must drop
        cfg_addr <= tcbpa_pkg::CFG_HEADER_BYTES;
        cfg_wdata <= {4'($urandom_range(0, 15)), hb};
        header_bytes_cfg = hb;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin : rsp_check
        tcbpa_pkg::rsp_payload_t due;
        tcbpa_pkg::rsp_payload_t got;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = rsp_if.payload;
            if (pool_results_due.size() == 0)
                report_mismatch("unexpected transaction status", got.status, -1);
            else
            begin
                due = pool_results_due.pop_front();
                if (got.status !== due.status)
                    report_mismatch("status", got.status, due.status);
                if (got.granted_id !== due.granted_id)
                    report_mismatch("granted_id", got.granted_id, due.granted_id);
                if (got.small_free_count !== due.small_free_count)
                    report_mismatch("small_free_count", got.small_free_count,
                                    due.small_free_count);
                if (got.large_free_count !== due.large_free_count)
                    report_mismatch("large_free_count", got.large_free_count,
                                    due.large_free_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rsp_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.payload <= '0;
        cfg_we <= 1'b0;
        cfg_addr <= tcbpa_pkg::CFG_SMALL_BYTES;
        cfg_wdata <= '0;
        pool_reset();

        // reset sizes: small 2048, large 16384, header 128
        plan(tcbpa_pkg::KIND_ALLOC, 0, 0, 1, tcbpa_pkg::STAT_OK, 1023, 1023, 128);
        plan(tcbpa_pkg::KIND_ALLOC, 65535, 2047, 1, tcbpa_pkg::STAT_TOO_LARGE, 0, 1023, 128);
        plan(tcbpa_pkg::KIND_ALLOC, 16256, 0, 1, tcbpa_pkg::STAT_OK, 1151, 1023, 127);
        plan(tcbpa_pkg::KIND_ALLOC, 16257, 0, 1, tcbpa_pkg::STAT_TOO_LARGE, 0, 1023, 127);
        plan(tcbpa_pkg::KIND_ALLOC, 1920, 0, 1, tcbpa_pkg::STAT_OK, 1022, 1022, 127);
        plan(tcbpa_pkg::KIND_ALLOC, 1921, 0, 1, tcbpa_pkg::STAT_OK, 1150, 1022, 126);
        plan(tcbpa_pkg::KIND_FREE, 65535, 2047, 1, tcbpa_pkg::STAT_BAD_ID, 0, 1022, 126);
        plan(tcbpa_pkg::KIND_FREE, 0, 1152, 1, tcbpa_pkg::STAT_BAD_ID, 0, 1022, 126);
        plan(tcbpa_pkg::KIND_FREE, 0, 0, 1, tcbpa_pkg::STAT_ALREADY_FREE, 0, 1022, 126);
        plan(tcbpa_pkg::KIND_FREE, 0, 1151, 1, tcbpa_pkg::STAT_OK, 0, 1022, 127);
        plan(tcbpa_pkg::KIND_FREE, 0, 1151, 1, tcbpa_pkg::STAT_ALREADY_FREE, 0, 1022, 127);
        plan(tcbpa_pkg::KIND_FREE, 0, 1023, 1, tcbpa_pkg::STAT_OK, 0, 1023, 127);
        plan(tcbpa_pkg::KIND_ALLOC, 100, 0, 1, tcbpa_pkg::STAT_OK, 1023, 1022, 127);
        plan(tcbpa_pkg::KIND_FREE, 0, 1024, 1, tcbpa_pkg::STAT_ALREADY_FREE, 0, 1022, 127);
        plan(tcbpa_pkg::KIND_ALLOC, 3000, 1151, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_FREE, 0, 1150, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_FREE, 0, 1022, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_ALLOC, 16'h5555, 11'h2AA, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_ALLOC, 16'h0AAA, 11'h555, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_FREE, 16'hFFFF, 1023, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);
        plan(tcbpa_pkg::KIND_FREE, 0, 1151, 0, tcbpa_pkg::STAT_OK, 0, 0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        idle_odds = 3;
        foreach (directed_rows[i])
            push_request(directed_rows[i].item, directed_rows[i].has_exp, directed_rows[i].due);

        // nearly everything lands in the large class, which runs dry
        drain_and_wait();
        set_sizes(16'd1, 16'd65535, 12'd0);
        idle_odds = 4;
        run_mix(240, 92, 1'b0);

        // small size above large size
        drain_and_wait();
        set_sizes(16'd65535, 16'd1, 12'd0);
        idle_odds = 2;
        run_mix(50, 60, 1'b0);

        drain_and_wait();
        set_sizes(16'd4096, 16'd8192, 12'd4095);
        idle_odds = 8;
        run_mix(120, 55, 1'b0);

        drain_and_wait();
        set_sizes(16'd512, 16'd60000, 12'd100);
        idle_odds = 5;
        run_mix(120, 50, 1'b0);

        // long run of small allocations
        drain_and_wait();
        set_sizes(tcbpa_pkg::SMALL_BYTES_RESET, tcbpa_pkg::LARGE_BYTES_RESET,
                  tcbpa_pkg::HEADER_BYTES_RESET);
        idle_odds = 6;
        run_mix(100, 100, 1'b1);

        drain_and_wait();
        set_sizes(16'd3000, 16'd9000, 12'd17);
        idle_odds = 0;
        run_mix(100, 25, 1'b0);

        drain_and_wait();
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
